### design/rtcv_pkg.sv
// Package for the recording trailer CRC verifier.
// Holds the trailer layout constants, the status codes and the CRC-32 byte update.
// It depends on nothing else.
package rtcv_pkg;

  localparam int TRAILER_LEN = 31;
  localparam int FILL_W = $clog2(TRAILER_LEN + 1);

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  localparam logic [7:0]  TYPE_BYTE  = 8'h08;
  localparam logic [31:0] TICK_WORD  = 32'hFFFF_FFFF;
  localparam logic [7:0]  SLOT_BYTE  = 8'h00;
  localparam logic [31:0] ID_WORD    = 32'h0000_0000;
  localparam logic [31:0] SIZE_LONG  = 32'h0000_0011;
  localparam logic [31:0] SIZE_SHORT = 32'h0000_000D;
  localparam logic [31:0] CURSOR_WORD = 32'hFFFF_FFFF;
  localparam logic [7:0]  MSG_ID_BYTE = 8'hFF;

  localparam int POS_TYPE     = 0;
  localparam int POS_TICK     = 1;
  localparam int POS_SLOT     = 5;
  localparam int POS_ID       = 6;
  localparam int POS_SIZE     = 10;
  localparam int POS_CURSOR_X = 14;
  localparam int POS_CURSOR_Y = 18;
  localparam int POS_MSG_ID   = 22;
  localparam int POS_FILE_CRC = 23;
  localparam int POS_TOOL_SUM = 27;

  localparam int OUT_DATA_W = 72;

  typedef enum logic [1:0] {
    STATUS_VALID      = 2'd0,
    STATUS_MISMATCH   = 2'd1,
    STATUS_NO_TRAILER = 2'd2,
    STATUS_TOO_SHORT  = 2'd3
  } status_t;

  typedef logic [7:0] window_t [TRAILER_LEN];

  function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic logic [31:0] le32(input window_t w, input int pos);
    return {w[pos + 3], w[pos + 2], w[pos + 1], w[pos]};
  endfunction

endpackage

### design/recording_trailer_crc_verifier_unit.sv
// Top level of the recording trailer CRC verifier.
// Holds the trailer delay line, the running CRC and the result register.
// Depends on rtcv_pkg.
//
// A file enters on the input stream one byte per request, in file order, with
// tlast set on its final byte. The newest 31 bytes wait in a shift line; each
// byte that leaves it is folded into a reflected CRC-32, so the CRC covers
// everything except the trailer. Only the request that carries tlast produces
// a result: status, stored tool checksum and computed CRC, packed in tdata.
// The result is registered and is valid on the output in the cycle after that last byte is taken.
// Throughput is one byte per cycle when the output is not stalled; the CRC
// byte update and the trailer compare both fit between the input handshake and
// the result register. The input is ready whenever the result register is empty
// or is being taken in the same cycle, so a stalled receiver holds back further
// input until the pending result leaves. After each file the CRC and the fill
// count return to their start values. Reset is synchronous and clears the fill
// count, the CRC and the output valid; the shift line contents need no reset.
module recording_trailer_crc_verifier_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [rtcv_pkg::OUT_DATA_W-1:0] m_axis_tdata
  // m_axis_tdata: [1:0] status, [33:2] stored_tool_sum, [65:34] computed_crc, [71:66] zero
);

  rtcv_pkg::window_t window;
  rtcv_pkg::window_t window_next;
  logic [31:0] crc;
  logic [31:0] crc_next;
  logic [rtcv_pkg::FILL_W-1:0] fill_count;
  logic [rtcv_pkg::FILL_W-1:0] fill_count_next;
  logic accept;
  logic window_full;
  logic header_ok;
  logic [31:0] size_word;
  logic [31:0] file_crc;
  rtcv_pkg::status_t status_next;
  logic [31:0] tool_next;
  logic [31:0] crc_out_next;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign window_full = (fill_count == rtcv_pkg::FILL_W'(rtcv_pkg::TRAILER_LEN));

  always_comb begin
    for (int i = 0; i < rtcv_pkg::TRAILER_LEN - 1; i++) begin
      window_next[i] = window[i + 1];
    end
    window_next[rtcv_pkg::TRAILER_LEN - 1] = s_axis_tdata;
  end

  assign crc_next = window_full ? rtcv_pkg::crc32_byte(crc, window[0]) : crc;
  assign fill_count_next = window_full ? fill_count : fill_count + 1'b1;

  assign size_word = rtcv_pkg::le32(window_next, rtcv_pkg::POS_SIZE);
  assign file_crc  = rtcv_pkg::le32(window_next, rtcv_pkg::POS_FILE_CRC);

  assign header_ok = (window_next[rtcv_pkg::POS_TYPE] == rtcv_pkg::TYPE_BYTE)
    && (rtcv_pkg::le32(window_next, rtcv_pkg::POS_TICK) == rtcv_pkg::TICK_WORD)
    && (window_next[rtcv_pkg::POS_SLOT] == rtcv_pkg::SLOT_BYTE)
    && (rtcv_pkg::le32(window_next, rtcv_pkg::POS_ID) == rtcv_pkg::ID_WORD)
    && ((size_word == rtcv_pkg::SIZE_LONG) || (size_word == rtcv_pkg::SIZE_SHORT))
    && (rtcv_pkg::le32(window_next, rtcv_pkg::POS_CURSOR_X) == rtcv_pkg::CURSOR_WORD)
    && (rtcv_pkg::le32(window_next, rtcv_pkg::POS_CURSOR_Y) == rtcv_pkg::CURSOR_WORD)
    && (window_next[rtcv_pkg::POS_MSG_ID] == rtcv_pkg::MSG_ID_BYTE);

  always_comb begin
    if (fill_count_next != rtcv_pkg::FILL_W'(rtcv_pkg::TRAILER_LEN)) begin
      status_next  = rtcv_pkg::STATUS_TOO_SHORT;
      tool_next    = 32'd0;
      crc_out_next = 32'd0;
    end else if (!header_ok) begin
      status_next  = rtcv_pkg::STATUS_NO_TRAILER;
      tool_next    = 32'd0;
      crc_out_next = ~crc_next;
    end else begin
      status_next  = (file_crc == ~crc_next) ? rtcv_pkg::STATUS_VALID
                                             : rtcv_pkg::STATUS_MISMATCH;
      tool_next    = rtcv_pkg::le32(window_next, rtcv_pkg::POS_TOOL_SUM);
      crc_out_next = ~crc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      window <= window_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc           <= rtcv_pkg::CRC_INIT;
      fill_count    <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (accept && s_axis_tlast) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (accept) begin
        if (s_axis_tlast) begin
          crc        <= rtcv_pkg::CRC_INIT;
          fill_count <= '0;
        end else begin
          crc        <= crc_next;
          fill_count <= fill_count_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && s_axis_tlast) begin
      m_axis_tdata <= {6'd0, crc_out_next, tool_next, status_next};
    end
  end

endmodule

### design/recording_trailer_crc_verifier_checker.sv
// Port-level checker for the recording trailer CRC verifier, with its bind.
// Watches the stream handshakes and the packed result fields over time.
// Depends on rtcv_pkg and on recording_trailer_crc_verifier_unit.
module rtcv_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [rtcv_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed or vanished while stalled");

  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast))
    else $error("result without an accepted last byte");

  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[1:0] == rtcv_pkg::STATUS_TOO_SHORT)
      |-> (m_axis_tdata[65:2] == 64'd0))
    else $error("short file reported nonzero checksum fields");

  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[1:0] == rtcv_pkg::STATUS_NO_TRAILER)
      |-> (m_axis_tdata[33:2] == 32'd0))
    else $error("missing trailer reported a tool checksum");

endmodule

bind recording_trailer_crc_verifier_unit rtcv_checker u_rtcv_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### tb/sv/trailer_verdict_checker.sv
// Checker for the recording trailer CRC verifier: watches both streams and
// predicts each file verdict from the bytes taken on the input side.
// Depends on rtcv_pkg for the status codes and the trailer layout constants.
module trailer_verdict_checker
  import rtcv_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [7:0]            in_byte,
  input  logic                  in_last,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [OUT_DATA_W-1:0] out_data,
  output int                    error_count,
  output int                    pending_verdicts,
  output int                    verdicts_checked
);

  typedef struct packed {
    status_t     status;
    logic [31:0] tool_sum;
    logic [31:0] file_crc;
  } verdict_t;

  verdict_t    expected_verdicts [$];
  logic [7:0]  shadow_window [TRAILER_LEN];
  logic [31:0] running_crc;
  int          bytes_held;
  int          err_total;
  int          checked_total;

  initial begin
    err_total = 0;
    checked_total = 0;
  end

  function automatic logic [31:0] fold_crc(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] c;
    c = acc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = {1'b0, c[31:1]} ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

  function automatic logic [31:0] window_word(input int pos);
    return {shadow_window[pos + 3], shadow_window[pos + 2],
            shadow_window[pos + 1], shadow_window[pos]};
  endfunction

  task automatic clear_file_state();
    for (int i = 0; i < TRAILER_LEN; i++) begin
      shadow_window[i] = 8'd0;
    end
    running_crc = CRC_INIT;
    bytes_held = 0;
  endtask

  task automatic take_byte(input logic [7:0] b, input logic is_last);
    verdict_t    v;
    logic [31:0] size_word;
    logic        header_ok;
    if (bytes_held >= TRAILER_LEN) begin
      running_crc = fold_crc(running_crc, shadow_window[0]);
      for (int i = 0; i < TRAILER_LEN - 1; i++) begin
        shadow_window[i] = shadow_window[i + 1];
      end
      shadow_window[TRAILER_LEN - 1] = b;
    end else begin
      shadow_window[bytes_held] = b;
      bytes_held++;
    end
    if (is_last) begin
      if (bytes_held < TRAILER_LEN) begin
        v.status = STATUS_TOO_SHORT;
        v.tool_sum = 32'd0;
        v.file_crc = 32'd0;
      end else begin
        v.file_crc = ~running_crc;
        size_word = window_word(POS_SIZE);
        header_ok = shadow_window[POS_TYPE] == TYPE_BYTE
                 && window_word(POS_TICK) == TICK_WORD
                 && shadow_window[POS_SLOT] == SLOT_BYTE
                 && window_word(POS_ID) == ID_WORD
                 && (size_word == SIZE_LONG || size_word == SIZE_SHORT)
                 && window_word(POS_CURSOR_X) == CURSOR_WORD
                 && window_word(POS_CURSOR_Y) == CURSOR_WORD
                 && shadow_window[POS_MSG_ID] == MSG_ID_BYTE;
        if (!header_ok) begin
          v.status = STATUS_NO_TRAILER;
          v.tool_sum = 32'd0;
        end else begin
          v.status = (window_word(POS_FILE_CRC) == v.file_crc) ? STATUS_VALID
                                                                : STATUS_MISMATCH;
          v.tool_sum = window_word(POS_TOOL_SUM);
        end
      end
      expected_verdicts.insert(expected_verdicts.size(), v);
      clear_file_state();
    end
  endtask

  task automatic compare_verdict(input logic [OUT_DATA_W-1:0] got);
    verdict_t want;
    if (expected_verdicts.size() == 0) begin
      $error("result arrived with no verdict expected: tdata %h", got);
      err_total++;
    end else begin
      want = expected_verdicts.pop_front();
      checked_total++;
      if (got[1:0] !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got[1:0]);
        err_total++;
      end
      if (got[33:2] !== want.tool_sum) begin
        $error("stored_tool_sum: expected %h, actual %h", want.tool_sum, got[33:2]);
        err_total++;
      end
      if (got[65:34] !== want.file_crc) begin
        $error("computed_crc: expected %h, actual %h", want.file_crc, got[65:34]);
        err_total++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_file_state();
      expected_verdicts.delete();
    end else begin
      if (out_valid && out_ready) begin
        compare_verdict(out_data);
      end
      if (in_valid && in_ready) begin
        take_byte(in_byte, in_last);
      end
    end
    error_count <= err_total;
    pending_verdicts <= expected_verdicts.size();
    verdicts_checked <= checked_total;
  end

endmodule

### tb/sv/testbench.sv
// Top of the verification bench for the recording trailer CRC verifier.
// Builds files with well-formed and damaged trailers, drives them with random
// gaps and output stalls, and gives the verdict; needs rtcv_pkg and the checker.
module testbench;
  import rtcv_pkg::*;

  localparam int ITEMS        = 1150;
  localparam int MIN_FILES    = 20;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 10;

  typedef enum int {
    FILE_INTACT,
    FILE_BAD_CRC,
    FILE_BAD_HEADER,
    FILE_SHORT,
    FILE_NOISE
  } file_kind_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = 8'd0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  int check_errors;
  int pending_verdicts;
  int verdicts_checked;

  bit idle_on = 1'b1;
  bit pressure_done = 1'b0;
  bit pressure_on = 1'b0;
  int quiet_cycles = 0;
  int bytes_sent = 0;
  int files_sent = 0;
  int kind_count [5];
  logic [7:0] file_bytes [$];

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  recording_trailer_crc_verifier_unit uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),   // [7:0] data_byte
    .s_axis_tlast  (s_tlast),   // last_byte
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)    // [1:0] status, [33:2] stored_tool_sum, [65:34] computed_crc
  );

  trailer_verdict_checker check (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (s_tvalid),
    .in_ready         (s_tready),
    .in_byte          (s_tdata),
    .in_last          (s_tlast),
    .out_valid        (m_tvalid),
    .out_ready        (m_tready),
    .out_data         (m_tdata),
    .error_count      (check_errors),
    .pending_verdicts (pending_verdicts),
    .verdicts_checked (verdicts_checked)
  );

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog: no request moved for %0d cycles.", QUIET_LIMIT);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // The result side; a pending long hold keeps the result register full so
  // the input side backs up behind it.
  initial begin : sink
    int span;
    forever begin
      if (!pressure_done && files_sent >= 8) begin
        pressure_done = 1'b1;
        pressure_on = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        pressure_on = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        span = $urandom_range(1, 10);
        m_tready <= 1'b0;
        repeat (span) @(posedge clk);
      end else begin
        span = $urandom_range(1, 20);
        m_tready <= 1'b1;
        repeat (span) @(posedge clk);
      end
    end
  end

  function automatic logic [31:0] body_crc_step(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] c;
    c = acc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = {1'b0, c[31:1]} ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

  task automatic append_byte(input logic [7:0] b);
    file_bytes.insert(file_bytes.size(), b);
  endtask

  task automatic put_word(input logic [31:0] w);
    for (int k = 0; k < 4; k++) begin
      append_byte(w[8*k +: 8]);
    end
  endtask

  task automatic make_file(input file_kind_t kind, input int body_len);
    logic [31:0] crc;
    logic [7:0]  b;
    int          pos;
    file_bytes.delete();
    crc = CRC_INIT;
    for (int i = 0; i < body_len; i++) begin
      b = 8'($urandom);
      append_byte(b);
      crc = body_crc_step(crc, b);
    end
    crc = ~crc;
    if (kind == FILE_SHORT || kind == FILE_NOISE) begin
      return;
    end
    append_byte(TYPE_BYTE);
    put_word(TICK_WORD);
    append_byte(SLOT_BYTE);
    put_word(ID_WORD);
    put_word($urandom_range(0, 1) ? SIZE_LONG : SIZE_SHORT);
    put_word(CURSOR_WORD);
    put_word(CURSOR_WORD);
    append_byte(MSG_ID_BYTE);
    put_word(kind == FILE_BAD_CRC ? crc ^ ($urandom | 32'd1) : crc);
    put_word($urandom);
    if (kind == FILE_BAD_HEADER) begin
      pos = body_len + $urandom_range(0, POS_MSG_ID);
      file_bytes[pos] = file_bytes[pos] ^ 8'($urandom_range(1, 255));
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic is_last);
    int gap;
    if (idle_on && !pressure_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 10);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= is_last;
    do @(posedge clk); while (!s_tready);
    bytes_sent++;
  endtask

  task automatic send_file(input file_kind_t kind);
    for (int i = 0; i < file_bytes.size(); i++) begin
      send_byte(file_bytes[i], i == file_bytes.size() - 1);
    end
    files_sent++;
    kind_count[kind]++;
  endtask

  initial begin : stimulus
    file_kind_t kind;
    int         pick;
    int         body_len;
    for (int i = 0; i < 5; i++) begin
      kind_count[i] = 0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // A lone final byte, then a file that is nothing but its trailer.
    file_bytes.delete();
    append_byte(8'hFF);
    send_file(FILE_SHORT);
    make_file(FILE_INTACT, 0);
    send_file(FILE_INTACT);

    while (bytes_sent < ITEMS || files_sent < MIN_FILES) begin
      if (bytes_sent >= ITEMS - 150) begin
        idle_on = 1'b0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        kind = FILE_INTACT;
      end else if (pick < 60) begin
        kind = FILE_BAD_CRC;
      end else if (pick < 75) begin
        kind = FILE_BAD_HEADER;
      end else if (pick < 87) begin
        kind = FILE_SHORT;
      end else begin
        kind = FILE_NOISE;
      end
      if (kind == FILE_SHORT) begin
        body_len = ($urandom_range(0, 3) == 0) ? TRAILER_LEN - 1
                                               : $urandom_range(1, TRAILER_LEN - 1);
      end else if (kind == FILE_NOISE) begin
        body_len = $urandom_range(TRAILER_LEN, 70);
      end else begin
        body_len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120)
                                               : $urandom_range(0, 24);
      end
      make_file(kind, body_len);
      send_file(kind);
    end
    s_tvalid <= 1'b0;

    do @(posedge clk); while (pending_verdicts != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d files in %0d bytes: %0d intact, %0d bad CRC,",
             files_sent, bytes_sent, kind_count[FILE_INTACT], kind_count[FILE_BAD_CRC]);
    $display("%0d bad header, %0d short, %0d noise; compared %0d verdicts with %0d errors.",
             kind_count[FILE_BAD_HEADER], kind_count[FILE_SHORT], kind_count[FILE_NOISE],
             verdicts_checked, check_errors);
    if (check_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
